@@ design/arpr_pkg.sv @@
`timescale 1ns / 1ps

package arpr_pkg;

    localparam int unsigned CNT_W = 6;

    localparam logic [CNT_W-1:0] HDR_LEN      = 6'd42;
    localparam logic [CNT_W-1:0] HDR_LAST_IDX = 6'd41;

    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
    localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
    localparam logic [15:0] ARP_OP_REPLY   = 16'h0002;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_MAC = 2'd0;
    localparam logic [1:0] CFG_OWN_IP  = 2'd1;

    typedef enum logic [0:0] {
        ST_RECV,
        ST_REPLY
    } arpr_state_t;

    // controller -> datapath
    typedef struct packed {
        logic             store;   // input beat accepted
        logic             issue;   // fetch reply byte idx
        logic [CNT_W-1:0] idx;
    } arpr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic reply_go;            // frame ended and asks for us
    } arpr_sts_t;

endpackage

@@ design/arpr_ctrl.sv @@
`timescale 1ns / 1ps

module arpr_ctrl
    import arpr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  arpr_sts_t sts,
    output arpr_cmd_t cmd
);

    arpr_state_t      state_reg, state_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             out_valid_reg, out_valid_next;
    logic             advance;
    logic             issue;
    logic             final_taken;

    assign advance     = !out_valid_reg || m_tready;
    assign issue       = (state_reg == ST_REPLY) && (k_reg < HDR_LEN) && advance;
    assign final_taken = out_valid_reg && m_tready && (k_reg == HDR_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RECV;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RECV:
            begin
                if (sts.reply_go)
                    state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                if (final_taken)
                    state_next = ST_RECV;
            end
            default: state_next = ST_RECV;
        endcase
    end

    // outputs and counters
    always_comb
    begin
        s_tready       = 1'b0;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        case (state_reg)
            ST_RECV:
            begin
                s_tready       = 1'b1;
                k_next         = '0;
                out_valid_next = 1'b0;
            end
            ST_REPLY:
            begin
                if (issue)
                begin
                    k_next         = k_reg + 1'b1;
                    out_valid_next = 1'b1;
                end
                else if (m_tready)
                    out_valid_next = 1'b0;
            end
            default:
            begin
                k_next         = '0;
                out_valid_next = 1'b0;
            end
        endcase
    end

    assign m_tvalid  = out_valid_reg;
    assign cmd.store = s_tvalid && s_tready;
    assign cmd.issue = issue;
    assign cmd.idx   = k_reg;

endmodule

@@ design/arpr_dp.sv @@
`timescale 1ns / 1ps

module arpr_dp
    import arpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic [7:0]  s_data,
    input  logic        s_last,
    output logic [7:0]  m_data,
    output logic        m_last,
    input  arpr_cmd_t   cmd,
    output arpr_sts_t   sts
);

    logic [7:0]       hdr_mem [0:41];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [47:0]      own_mac_reg;
    logic [31:0]      own_ip_reg;
    logic [15:0]      etype_reg;
    logic [15:0]      op_reg;
    logic [31:0]      tpa_reg;
    logic [7:0]       rd_data_reg;
    logic [7:0]       const_byte_reg;
    logic             sel_mem_reg;
    logic             last_reg;

    logic             wr_en;
    logic             full;
    logic [7:0]       tpa_lo;
    logic [CNT_W-1:0] rd_addr;
    logic [7:0]       const_byte;
    logic             sel_mem;
    logic [2:0]       mac_idx;
    logic [1:0]       ip_idx;
    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] k_mac2;
    logic [CNT_W-1:0] k_ip;

    assign wr_en = cmd.store && (count_reg < HDR_LEN);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OWN_MAC: own_mac_reg <= cfg_data;
                CFG_OWN_IP:  own_ip_reg  <= cfg_data[31:0];
                default:     ;
            endcase
        end
    end

    // byte count, saturating, cleared at frame end
    always_comb
    begin
        count_next = count_reg;
        if (cmd.store)
        begin
            if (s_last)
                count_next = '0;
            else if (count_reg < HDR_LEN)
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // capture of checked fields as they pass
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            case (count_reg)
                6'd12:   etype_reg[15:8] <= s_data;
                6'd13:   etype_reg[7:0]  <= s_data;
                6'd20:   op_reg[15:8]    <= s_data;
                6'd21:   op_reg[7:0]     <= s_data;
                6'd38:   tpa_reg[31:24]  <= s_data;
                6'd39:   tpa_reg[23:16]  <= s_data;
                6'd40:   tpa_reg[15:8]   <= s_data;
                6'd41:   tpa_reg[7:0]    <= s_data;
                default: ;
            endcase
        end
    end

    // last header byte may be the frame-end beat itself
    assign full   = (count_reg == HDR_LEN) || (count_reg == HDR_LAST_IDX);
    assign tpa_lo = (count_reg == HDR_LAST_IDX) ? s_data : tpa_reg[7:0];

    assign sts.reply_go = cmd.store && s_last && full
                        && (etype_reg == ETHERTYPE_ARP)
                        && (op_reg == ARP_OP_REQUEST)
                        && ({tpa_reg[31:8], tpa_lo} == own_ip_reg);

    // reply byte source
    assign k      = cmd.idx;
    assign k_mac2 = k - 6'd22;
    assign k_ip   = k - 6'd28;

    always_comb
    begin
        sel_mem = 1'b1;
        rd_addr = '0;
        mac_idx = '0;
        ip_idx  = '0;
        if (k < 6'd6)
            rd_addr = k + 6'd6;
        else if (k < 6'd12)
        begin
            sel_mem = 1'b0;
            mac_idx = k[2:0] - 3'd6;
        end
        else if (k < 6'd20)
            rd_addr = k;
        else if (k < 6'd22)
            sel_mem = 1'b0;
        else if (k < 6'd28)
        begin
            sel_mem = 1'b0;
            mac_idx = k_mac2[2:0];
        end
        else if (k < 6'd32)
        begin
            sel_mem = 1'b0;
            ip_idx  = k_ip[1:0];
        end
        else
            rd_addr = k - 6'd10;
    end

    always_comb
    begin
        const_byte = '0;
        if ((k >= 6'd6 && k < 6'd12) || (k >= 6'd22 && k < 6'd28))
        begin
            case (mac_idx)
                3'd0:    const_byte = own_mac_reg[47:40];
                3'd1:    const_byte = own_mac_reg[39:32];
                3'd2:    const_byte = own_mac_reg[31:24];
                3'd3:    const_byte = own_mac_reg[23:16];
                3'd4:    const_byte = own_mac_reg[15:8];
                default: const_byte = own_mac_reg[7:0];
            endcase
        end
        else if (k == 6'd20)
            const_byte = ARP_OP_REPLY[15:8];
        else if (k == 6'd21)
            const_byte = ARP_OP_REPLY[7:0];
        else
        begin
            case (ip_idx)
                2'd0:    const_byte = own_ip_reg[31:24];
                2'd1:    const_byte = own_ip_reg[23:16];
                2'd2:    const_byte = own_ip_reg[15:8];
                default: const_byte = own_ip_reg[7:0];
            endcase
        end
    end

    // header store and reply output register
    always_ff @(posedge clk)
    begin
        if (wr_en)
            hdr_mem[count_reg] <= s_data;
        if (cmd.issue)
        begin
            rd_data_reg    <= hdr_mem[rd_addr];
            const_byte_reg <= const_byte;
            sel_mem_reg    <= sel_mem;
            last_reg       <= (k == HDR_LAST_IDX);
        end
    end

    assign m_data = sel_mem_reg ? rd_data_reg : const_byte_reg;
    assign m_last = last_reg;

endmodule

@@ design/arp_request_responder_core.sv @@
`timescale 1ns / 1ps

// ARP responder for IPv4 over Ethernet. Received frame bytes stream in on
// the slave side one beat per cycle, tlast on the final byte; the first 42
// bytes (Ethernet header plus ARP body) are kept in a small header store
// and anything after them is dropped. At the frame-end beat the block
// checks EtherType 0x0806, opcode request and target IP against own_ip_addr;
// on a match it sends a 42-byte ARP reply on the master side (peer as
// target, own MAC and IP as sender, opcode reply, tlast on the last byte).
// Short frames and non-matching frames give nothing. Input runs at one beat
// per cycle. A matching frame end sets the reply state; each reply byte is
// then registered and drains at one beat per cycle while m_tready is held,
// paced by the single read port of the header store; s_tready is low after
// the frame-end beat of a matching frame until the last reply beat is
// taken. Config writes are always accepted (cfg_ready tied high);
// indexes other than 0 (own MAC) and 1 (own IP) are ignored.

module arp_request_responder_core
    import arpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,    // 0: own_mac_addr, 1: own_ip_addr
    input  logic [47:0] cfg_data,     // own_mac_addr[47:0] or own_ip_addr[31:0]

    // received frame
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] data_byte
    input  logic        s_tlast,      // frame_end

    // ARP reply
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,      // [7:0] reply_byte
    output logic        m_tlast       // reply_last
);

    arpr_cmd_t cmd;
    arpr_sts_t sts;

    assign cfg_ready = 1'b1;

    // sequencing: receive / reply, beat counter, output valid
    arpr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // header store, field checks, reply byte assembly
    arpr_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_tdata),
        .s_last    (s_tlast),
        .m_data    (m_tdata),
        .m_last    (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ sim/arp_request_responder_core_tb.sv @@
`timescale 1ns / 1ps

module arp_request_responder_core_tb;
    import arpr_pkg::*;

    // spare register indexes: the block must ignore writes to them
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    // fixed ARP header values and byte offsets within a received frame
    localparam logic [15:0] HTYPE_ETH  = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  HLEN_ETH   = 8'd6;
    localparam logic [7:0]  PLEN_IPV4  = 8'd4;
    localparam int unsigned OFS_ETYPE  = 12;
    localparam int unsigned OFS_OPCODE = 20;
    localparam int unsigned OFS_TGT_IP = 38;

    localparam int unsigned REPLY_BEATS = HDR_LEN;
    localparam int unsigned MAX_FRAME   = 100;
    localparam int unsigned IDLE_PCT    = 12;
    localparam int unsigned TAIL_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef enum logic [2:0] {
        FK_MATCH,
        FK_BAD_ETYPE,
        FK_BAD_OP,
        FK_BAD_IP,
        FK_SHORT,
        FK_NOISE
    } frame_kind_t;

    // one pending slave-side beat; hold marks a pause until all replies are in
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hold;
    } frame_beat_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } reply_beat_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_OWN_MAC;
    logic [47:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    // stimulus and bookkeeping
    frame_beat_t  frame_q [$];
    reply_beat_t  reply_q [$];
    int unsigned  beats_queued = 0;   // written by the stimulus process only
    int unsigned  beats_taken  = 0;   // NBA from the driver
    logic         replies_idle = 1'b1; // NBA from the monitor: nothing expected
    logic         steady       = 1'b0; // no idling on either side while set
    int unsigned  mismatch_cnt = 0;
    int unsigned  cycle_cnt    = 0;

    // predictor state: own copy of the registers, the header store and the count
    logic [47:0] my_mac = '0;
    logic [31:0] my_ip  = '0;
    logic [7:0]  hdr_bytes [0:REPLY_BEATS-1];
    logic [5:0]  hdr_count = '0;

    arp_request_responder_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // true when the stored header is an ARP request for our IP
    function automatic logic asks_for_us();
        logic [15:0] etype;
        logic [15:0] opcode;
        logic [31:0] tgt_ip;
        etype  = {hdr_bytes[OFS_ETYPE], hdr_bytes[OFS_ETYPE+1]};
        opcode = {hdr_bytes[OFS_OPCODE], hdr_bytes[OFS_OPCODE+1]};
        tgt_ip = {hdr_bytes[OFS_TGT_IP], hdr_bytes[OFS_TGT_IP+1],
                  hdr_bytes[OFS_TGT_IP+2], hdr_bytes[OFS_TGT_IP+3]};
        return etype == ETHERTYPE_ARP && opcode == ARP_OP_REQUEST && tgt_ip == my_ip;
    endfunction

    // reply byte k: peer MAC swapped to destination, own MAC/IP as sender,
    // opcode reply, requester's MAC/IP as target
    function automatic logic [7:0] reply_byte_at(input int unsigned k);
        if (k < 6)
            return hdr_bytes[6 + k];
        else if (k < 12)
            return my_mac[8 * (11 - k) +: 8];
        else if (k < OFS_OPCODE)
            return hdr_bytes[k];
        else if (k == OFS_OPCODE)
            return ARP_OP_REPLY[15:8];
        else if (k == OFS_OPCODE + 1)
            return ARP_OP_REPLY[7:0];
        else if (k < 28)
            return my_mac[8 * (27 - k) +: 8];
        else if (k < 32)
            return my_ip[8 * (31 - k) +: 8];
        else
            return hdr_bytes[k - 10];
    endfunction

    // one accepted frame beat; queues the whole reply on a matching frame end
    function automatic void take_frame_byte(input logic [7:0] b, input logic last);
        if (hdr_count < HDR_LEN)
        begin
            hdr_bytes[hdr_count] = b;
            hdr_count = hdr_count + 1'b1;
        end
        if (last)
        begin
            if (hdr_count == HDR_LEN && asks_for_us())
                for (int unsigned k = 0; k < REPLY_BEATS; k++)
                    reply_q.push_back('{data: reply_byte_at(k),
                                        last: (k == REPLY_BEATS - 1)});
            hdr_count = '0;
        end
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t: mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Driver: slave side, fed from frame_q. Idles about 12 beats in 100
    // unless steady is set; a hold marker stalls it until every reply
    // predicted so far has come back.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : frame_driver
        frame_beat_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                beats_taken <= beats_taken + 1;
            if (!s_tvalid || s_tready)
            begin
                if (frame_q.size() != 0 && frame_q[0].hold)
                begin
                    // only release once nothing was in flight at this edge
                    if (!s_tvalid && replies_idle)
                        void'(frame_q.pop_front());
                    s_tvalid <= 1'b0;
                end
                else if (frame_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = frame_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                end
                else
                begin
                    // junk on the bus while idle; must be ignored
                    s_tvalid <= 1'b0;
                    s_tdata  <= 8'($urandom);
                    s_tlast  <= 1'($urandom);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted frame beat and checks every
    // accepted reply beat against the oldest expectation, in one process
    // so push and pop never race.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : reply_monitor
        reply_beat_t want;
        int unsigned idx;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                take_frame_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (reply_q.size() == 0)
                begin
                    note_mismatch($sformatf("reply beat with none pending: tdata %h tlast %b",
                                            m_tdata, m_tlast));
                end
                else
                begin
                    want = reply_q.pop_front();
                    idx  = REPLY_BEATS - 1 - (reply_q.size() % REPLY_BEATS);
                    if (m_tdata !== want.data)
                        note_mismatch($sformatf("reply byte %0d tdata expected %h got %h",
                                                idx, want.data, m_tdata));
                    if (m_tlast !== want.last)
                        note_mismatch($sformatf("reply byte %0d tlast expected %b got %b",
                                                idx, want.last, m_tlast));
                end
            end
            replies_idle <= (reply_q.size() == 0);
        end
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_beat(input logic [7:0] b, input logic last);
        frame_q.push_back('{data: b, last: last, hold: 1'b0});
        beats_queued++;
    endtask

    task automatic push_hold();
        frame_q.push_back('{data: 8'h00, last: 1'b0, hold: 1'b1});
    endtask

    // builds one frame of the given kind around the current own IP
    task automatic queue_frame(input frame_kind_t kind);
        logic [7:0]  fr [0:MAX_FRAME-1];
        int unsigned len;
        int unsigned pick;
        logic [15:0] bad;
        pick = $urandom_range(99);
        if (kind == FK_SHORT)
            len = ($urandom_range(3) == 0) ? REPLY_BEATS - 1 : $urandom_range(1, REPLY_BEATS - 1);
        else if (kind == FK_NOISE)
            len = $urandom_range(1, 80);
        else if (pick < 40)
            len = REPLY_BEATS;
        else if (pick < 90)
            len = $urandom_range(REPLY_BEATS + 1, 64);
        else
            len = $urandom_range(65, MAX_FRAME);

        for (int unsigned i = 0; i < MAX_FRAME; i++)
            fr[i] = 8'($urandom);

        if (kind != FK_NOISE)
        begin
            if ($urandom_range(1) == 1)
                for (int unsigned i = 0; i < 6; i++)
                    fr[i] = 8'hFF;   // broadcast destination
            {fr[OFS_ETYPE], fr[OFS_ETYPE+1]} = ETHERTYPE_ARP;
            // usually a proper Ethernet/IPv4 ARP body; otherwise random, just echoed
            if ($urandom_range(3) != 0)
            begin
                {fr[14], fr[15]} = HTYPE_ETH;
                {fr[16], fr[17]} = PTYPE_IPV4;
                fr[18] = HLEN_ETH;
                fr[19] = PLEN_IPV4;
            end
            {fr[OFS_OPCODE], fr[OFS_OPCODE+1]} = ARP_OP_REQUEST;
            {fr[OFS_TGT_IP], fr[OFS_TGT_IP+1], fr[OFS_TGT_IP+2], fr[OFS_TGT_IP+3]} = my_ip;
            case (kind)
                FK_BAD_ETYPE:
                begin
                    bad = ($urandom_range(1) == 1) ? ETHERTYPE_ARP ^ (16'h1 << $urandom_range(15))
                                                   : 16'($urandom);
                    {fr[OFS_ETYPE], fr[OFS_ETYPE+1]} = bad;
                end
                FK_BAD_OP:
                begin
                    bad = ($urandom_range(1) == 1) ? ARP_OP_REPLY
                                                   : ARP_OP_REQUEST ^ (16'h1 << $urandom_range(15));
                    {fr[OFS_OPCODE], fr[OFS_OPCODE+1]} = bad;
                end
                FK_BAD_IP:
                    // one target IP byte off, so each byte compare is exercised
                    fr[OFS_TGT_IP + $urandom_range(3)] ^= 8'($urandom_range(1, 255));
                default:
                    ;
            endcase
        end

        for (int unsigned i = 0; i < len; i++)
            push_beat(fr[i], i == len - 1);
    endtask

    function automatic frame_kind_t pick_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50)      return FK_MATCH;
        else if (r < 60) return FK_BAD_ETYPE;
        else if (r < 70) return FK_BAD_OP;
        else if (r < 80) return FK_BAD_IP;
        else if (r < 90) return FK_SHORT;
        else             return FK_NOISE;
    endfunction

    // random frames until about budget beats are queued; an occasional pause
    task automatic queue_random_frames(input int unsigned budget);
        int unsigned start;
        start = beats_queued;
        while (beats_queued - start < budget)
        begin
            queue_frame(pick_kind());
            if ($urandom_range(99) < 8)
                push_hold();
        end
    endtask

    // everything sent, every reply in, then the pipeline given time to settle
    task automatic wait_quiet();
        while (beats_taken != beats_queued)
            @(posedge clk);
        while (!replies_idle)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        while (!replies_idle)
            @(posedge clk);
    endtask

    // register write; only called while the block is quiet
    task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_OWN_MAC)
            my_mac = value;
        else if (idx == CFG_OWN_IP)
            my_ip = value[31:0];
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // spare indexes must leave both registers at their reset value
        write_reg(CFG_SPARE_2, {48{1'b1}});
        write_reg(CFG_SPARE_3, rand48());

        // directed: one-beat and tiny frames, all-zero and all-one bytes
        push_beat(8'hFF, 1'b1);
        push_beat(8'h00, 1'b1);
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b1);
        push_beat(8'hA5, 1'b0);
        push_beat(8'h5A, 1'b0);
        push_beat(8'h00, 1'b1);

        // every frame shape at least once with reset config (own IP 0.0.0.0), then mixed
        queue_frame(FK_MATCH);
        push_hold();
        queue_frame(FK_BAD_ETYPE);
        queue_frame(FK_BAD_OP);
        queue_frame(FK_BAD_IP);
        queue_frame(FK_SHORT);
        queue_frame(FK_MATCH);
        queue_frame(FK_NOISE);
        queue_random_frames(10);
        wait_quiet();

        // all-ones registers, junk above bit 31 on the IP write; no idling
        write_reg(CFG_OWN_MAC, {48{1'b1}});
        write_reg(CFG_OWN_IP, {16'($urandom), 32'hFFFF_FFFF});
        steady <= 1'b1;
        queue_random_frames(40);
        wait_quiet();
        steady <= 1'b0;

        // zero MAC, random IP
        write_reg(CFG_OWN_MAC, 48'h0);
        write_reg(CFG_OWN_IP, {16'h0, 32'($urandom)});
        queue_random_frames(10);
        push_hold();
        wait_quiet();

        // random everything, spare write in between must not disturb it
        write_reg(CFG_OWN_IP, rand48());
        write_reg(CFG_OWN_MAC, rand48());
        write_reg(CFG_SPARE_3, rand48());
        queue_random_frames(10);
        wait_quiet();

        if (mismatch_cnt == 0 && reply_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
